FILE: sv/psg_stereo_mix_svf_lowpass_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stereo mixer / low-pass filter block
// Shared concurrent-assertion shorthands used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef PSG_STEREO_MIX_SVF_LOWPASS_DEFINES_SVH
`define PSG_STEREO_MIX_SVF_LOWPASS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psm assertion failed");

// next-cycle implication, disabled during reset
`define PSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psm assertion failed");

`endif

FILE: sv/psm_pkg.sv
// ---------------------------------------------------------------------------
// psm_pkg
// Types, constants and helper functions of the stereo mixer with low-pass.
// ---------------------------------------------------------------------------
package psm_pkg;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_FILTER_EN = 3'd0,
      CSR_LEFT_EN   = 3'd1,
      CSR_RIGHT_EN  = 3'd2,
      CSR_FREQ      = 3'd3,
      CSR_DAMPING   = 3'd4
   } csr_index_type;

   // lane sequencer steps
   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_LOW,
      STEP_HIGH,
      STEP_MULH,
      STEP_BAND,
      STEP_DONE
   } lane_step_type;

   localparam logic [7:0]  MUTE_LEVEL    = 8'h7F;
   localparam logic [14:0] FREQ_RESET    = 15'd6950;
   localparam logic [14:0] DAMPING_RESET = 15'd27853;
   // floor(v/3) for v < 768 as (v*683) >> 11
   localparam logic [9:0]  RECIP3        = 10'd683;

   // controls from the config registers into a lane
   typedef struct packed {
      logic        chan_en;
      logic        filter_en;
      logic [14:0] freq;
      logic [14:0] damping;
   } lane_ctl_type;

   // lane status toward the output stage
   typedef struct packed {
      logic       idle;
      logic       done;
      logic [7:0] sample;
   } lane_status_type;

   // saturate a 36-bit signed value to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic [35:0] v);
      logic [31:0] r;
      if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
         r = v[31:0];
      end else if (v[35]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   // integer part of a Q16.16 value, clamped to 0..255
   function automatic logic [7:0] sat8(input logic [31:0] v);
      logic [7:0] r;
      if (v[31]) begin
         r = 8'd0;
      end else if (|v[30:24]) begin
         r = 8'hFF;
      end else begin
         r = v[23:16];
      end
      return r;
   endfunction

endpackage

FILE: sv/psm_lane.sv
// ---------------------------------------------------------------------------
// psm_lane
// One mix channel: forms (centre + 2*side) >> 8 / 3 and steps the low-pass
// filter through one shared 16x32 multiplier in steps LOW, HIGH, MULH, BAND.
// ---------------------------------------------------------------------------
module psm_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [15:0]              centre,
   input  logic [15:0]              side,
   input  psm_pkg::lane_ctl_type    ctl,
   input  logic                     take,
   output psm_pkg::lane_status_type status
);

   psm_pkg::lane_step_type step_ff, step_in;

   logic [31:0]        low_ff, low_in;
   logic [31:0]        band_ff, band_in;
   logic [31:0]        l_ff, l_in;
   logic [31:0]        h_ff, h_in;
   logic signed [47:0] prod_ff, prod_in;
   logic [7:0]         mix_ff, mix_in;
   logic [7:0]         sample_ff, sample_in;

   logic [17:0]        mix_sum;
   logic [19:0]        mix_scaled;
   logic signed [15:0] mul_coef;
   logic signed [31:0] mul_data;
   logic [35:0]        prod_sh;
   logic [35:0]        low_sum;
   logic [35:0]        high_sum;
   logic [35:0]        band_sum;
   logic [35:0]        x_ext;
   logic [31:0]        b_sat;

   // mix: divide by 3 through the reciprocal multiply
   assign mix_sum    = {2'b00, centre} + {1'b0, side, 1'b0};
   assign mix_scaled = mix_sum[17:8] * psm_pkg::RECIP3;

   // floor shift of the held product by 14
   assign prod_sh = {{2{prod_ff[47]}}, prod_ff[47:14]};
   assign x_ext   = {12'd0, mix_ff, 16'd0};

   assign low_sum  = {{4{low_ff[31]}}, low_ff} + prod_sh;
   assign high_sum = x_ext - {{4{l_ff[31]}}, l_ff} - prod_sh;
   assign band_sum = prod_sh + {{4{band_ff[31]}}, band_ff};
   assign b_sat    = psm_pkg::sat32(band_sum);

   // shared multiplier operand select
   always_comb begin
      mul_coef = signed'({1'b0, ctl.freq});
      mul_data = signed'(band_ff);
      case (step_ff)
         psm_pkg::STEP_LOW: begin
            mul_coef = signed'({1'b0, ctl.damping});
         end
         psm_pkg::STEP_MULH: begin
            mul_data = signed'(h_ff);
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_coef * mul_data;

   // sequencer
   always_comb begin
      step_in   = step_ff;
      low_in    = low_ff;
      band_in   = band_ff;
      l_in      = l_ff;
      h_in      = h_ff;
      mix_in    = mix_ff;
      sample_in = sample_ff;
      case (step_ff)
         psm_pkg::STEP_IDLE: begin
            if (start) begin
               mix_in  = mix_scaled[18:11];
               step_in = psm_pkg::STEP_LOW;
            end
         end
         psm_pkg::STEP_LOW: begin
            l_in    = psm_pkg::sat32(low_sum);
            step_in = psm_pkg::STEP_HIGH;
         end
         psm_pkg::STEP_HIGH: begin
            h_in    = psm_pkg::sat32(high_sum);
            step_in = psm_pkg::STEP_MULH;
         end
         psm_pkg::STEP_MULH: begin
            step_in = psm_pkg::STEP_BAND;
         end
         psm_pkg::STEP_BAND: begin
            // state moves only for an enabled, filtered channel
            if (ctl.chan_en && ctl.filter_en) begin
               low_in  = l_ff;
               band_in = b_sat;
            end
            sample_in = ctl.filter_en ? psm_pkg::sat8(l_ff) : mix_ff;
            step_in   = psm_pkg::STEP_DONE;
         end
         psm_pkg::STEP_DONE: begin
            if (take) begin
               step_in = psm_pkg::STEP_IDLE;
            end
         end
         default: begin
            step_in = psm_pkg::STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= psm_pkg::STEP_IDLE;
         low_ff  <= 32'd0;
         band_ff <= 32'd0;
      end else begin
         step_ff <= step_in;
         low_ff  <= low_in;
         band_ff <= band_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      l_ff      <= l_in;
      h_ff      <= h_in;
      mix_ff    <= mix_in;
      sample_ff <= sample_in;
      prod_ff   <= prod_in;
   end

   assign status.idle   = (step_ff == psm_pkg::STEP_IDLE);
   assign status.done   = (step_ff == psm_pkg::STEP_DONE);
   assign status.sample = sample_ff;

endmodule

FILE: sv/psm_merge.sv
// ---------------------------------------------------------------------------
// psm_merge
// Joins the two lane results, applies muting and holds the output word.
// ---------------------------------------------------------------------------
module psm_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  psm_pkg::lane_status_type left_status,
   input  psm_pkg::lane_status_type right_status,
   input  logic                     left_en,
   input  logic                     right_en,
   output logic                     take,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata
);

   logic        valid_ff, valid_in;
   logic [15:0] data_ff, data_in;

   // lanes run in lockstep; load when the output register frees up
   assign take = left_status.done && right_status.done && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in      = 1'b1;
         data_in[7:0]  = left_en  ? left_status.sample  : psm_pkg::MUTE_LEVEL;
         data_in[15:8] = right_en ? right_status.sample : psm_pkg::MUTE_LEVEL;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

FILE: sv/psg_stereo_mix_svf_lowpass.sv
// ---------------------------------------------------------------------------
// psg_stereo_mix_svf_lowpass
// Stereo mixer for three tone-chip levels with a per-channel low-pass filter.
// ---------------------------------------------------------------------------
// An accepted req word passes the lane steps LOW, HIGH, MULH, BAND and DONE and then
// the output register. Each lane walks its filter step through one shared 16x32
// multiplier (three products per word), and takes no new word until DONE is left.
// A finished result waits in the output register while the lanes take the next word.
// Reset (synchronous, active high) clears filter state to zero and restores
// the register defaults: filter off, both channels on, F=6950, Q=27853.
module psg_stereo_mix_svf_lowpass (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: level_a [15:0], level_b [31:16], level_c [47:32]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // rsp_tdata: left_sample [7:0], right_sample [15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_data
);

   `include "psg_stereo_mix_svf_lowpass_defines.svh"

   logic        filter_en_ff, filter_en_in;
   logic        left_en_ff, left_en_in;
   logic        right_en_ff, right_en_in;
   logic [14:0] freq_ff, freq_in;
   logic [14:0] damping_ff, damping_in;

   logic                     start;
   logic                     take;
   psm_pkg::lane_ctl_type    left_ctl;
   psm_pkg::lane_ctl_type    right_ctl;
   psm_pkg::lane_status_type left_status;
   psm_pkg::lane_status_type right_status;

   // config registers
   assign csr_ready = 1'b1;

   always_comb begin
      filter_en_in = filter_en_ff;
      left_en_in   = left_en_ff;
      right_en_in  = right_en_ff;
      freq_in      = freq_ff;
      damping_in   = damping_ff;
      if (csr_valid) begin
         case (psm_pkg::csr_index_type'(csr_index))
            psm_pkg::CSR_FILTER_EN: filter_en_in = csr_data[0];
            psm_pkg::CSR_LEFT_EN:   left_en_in   = csr_data[0];
            psm_pkg::CSR_RIGHT_EN:  right_en_in  = csr_data[0];
            psm_pkg::CSR_FREQ:      freq_in      = csr_data;
            psm_pkg::CSR_DAMPING:   damping_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_en_ff <= 1'b0;
         left_en_ff   <= 1'b1;
         right_en_ff  <= 1'b1;
         freq_ff      <= psm_pkg::FREQ_RESET;
         damping_ff   <= psm_pkg::DAMPING_RESET;
      end else begin
         filter_en_ff <= filter_en_in;
         left_en_ff   <= left_en_in;
         right_en_ff  <= right_en_in;
         freq_ff      <= freq_in;
         damping_ff   <= damping_in;
      end
   end

   // input handshake: a word enters when both lanes are free
   assign req_tready = left_status.idle && right_status.idle;
   assign start      = req_tvalid && req_tready;

   assign left_ctl  = '{chan_en: left_en_ff, filter_en: filter_en_ff,
                        freq: freq_ff, damping: damping_ff};
   assign right_ctl = '{chan_en: right_en_ff, filter_en: filter_en_ff,
                        freq: freq_ff, damping: damping_ff};

   // left lane: B + 2A
   psm_lane u_left (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .centre (req_tdata[31:16]),
      .side   (req_tdata[15:0]),
      .ctl    (left_ctl),
      .take   (take),
      .status (left_status)
   );

   // right lane: B + 2C
   psm_lane u_right (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .centre (req_tdata[31:16]),
      .side   (req_tdata[47:32]),
      .ctl    (right_ctl),
      .take   (take),
      .status (right_status)
   );

   // output stage
   psm_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .left_status  (left_status),
      .right_status (right_status),
      .left_en      (left_en_ff),
      .right_en     (right_en_ff),
      .take         (take),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   // lanes stay in lockstep
   `PSM_ASSERT_SAME(a_lockstep, clock, reset, left_status.idle != right_status.idle, 1'b0)
   // an accepted word occupies the lanes on the next cycle
   `PSM_ASSERT_NEXT(a_busy_after_start, clock, reset, start, !req_tready)
   // a result handed over shows up at the output
   `PSM_ASSERT_NEXT(a_take_shows, clock, reset, take, rsp_tvalid && req_tready)

endmodule

FILE: tb/tb_psg_stereo_mix_svf_lowpass.sv
// ---------------------------------------------------------------------------
// tb_psg_stereo_mix_svf_lowpass
// Self-checking bench for the stereo mixer with per-channel low-pass filter.
// Frames of three channel levels go in on the req stream, and a bit-exact
// model of the mix and the filter predicts each stereo sample pair on rsp.
// Register settings change between test phases, only once the block has
// drained. Both streams stall at random, and one phase holds off the
// receiver long enough to back the block up.
// ---------------------------------------------------------------------------
module tb_psg_stereo_mix_svf_lowpass;

   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word on any channel
   localparam int SETTLE_CYCLES  = 16;    // settle time after the final drain
   localparam int IDLE_PERCENT   = 16;
   localparam int CSR_COUNT      = 5;     // first index with no register
   localparam int LANE_LEFT      = 0;
   localparam int LANE_RIGHT     = 1;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_FRAMES   = 118;

   typedef struct packed {
      logic [7:0] right_sample;
      logic [7:0] left_sample;
   } stereo_pair_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // level_a [15:0], level_b [31:16], level_c [47:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // left_sample [7:0], right_sample [15:8]
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [14:0] csr_data;

   // model copy of the registers and filter state
   logic              mdl_filter_en;
   logic              mdl_left_en;
   logic              mdl_right_en;
   logic [14:0]       mdl_freq;
   logic [14:0]       mdl_damping;
   logic signed [31:0] lp_low [2];
   logic signed [31:0] lp_band [2];

   stereo_pair_type pending_samples[$];
   int              fail_count;
   int              quiet_cycles;
   bit              no_gaps;
   bit              rsp_hold_req;

   psg_stereo_mix_svf_lowpass u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- prediction ----------------

   function automatic longint clamp32(input longint v);
      longint r;
      r = v;
      if (v > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) r = -64'sh8000_0000;
      return r;
   endfunction

   // ((centre + 2*side) >> 8) / 3
   function automatic logic [7:0] stereo_mix(input logic [15:0] centre, input logic [15:0] side);
      int unsigned s;
      s = centre;
      s = s + 2 * side;
      return 8'((s >> 8) / 3);
   endfunction

   // one low-pass step on a lane; products floor-shifted by 14, sums saturated
   function automatic logic [7:0] lowpass_step(input int lane, input logic [7:0] mix);
      longint f, q, x, band, l, h, b;
      f    = mdl_freq;
      q    = mdl_damping;
      x    = mix;
      x    = x << 16;
      band = lp_band[lane];
      l    = clamp32(longint'(lp_low[lane]) + ((f * band) >>> 14));
      h    = clamp32(x - l - ((q * band) >>> 14));
      b    = clamp32(((f * h) >>> 14) + band);
      lp_band[lane] = b[31:0];
      lp_low[lane]  = l[31:0];
      if (l < 0) return 8'd0;
      if ((l >>> 16) > 255) return 8'hFF;
      return l[23:16];
   endfunction

   function automatic void predict_stereo_frame(input logic [47:0] word);
      stereo_pair_type p;
      p.left_sample  = psm_pkg::MUTE_LEVEL;
      p.right_sample = psm_pkg::MUTE_LEVEL;
      if (mdl_left_en) begin
         p.left_sample = stereo_mix(word[31:16], word[15:0]);
         if (mdl_filter_en) p.left_sample = lowpass_step(LANE_LEFT, p.left_sample);
      end
      if (mdl_right_en) begin
         p.right_sample = stereo_mix(word[31:16], word[47:32]);
         if (mdl_filter_en) p.right_sample = lowpass_step(LANE_RIGHT, p.right_sample);
      end
      pending_samples.push_back(p);
   endfunction

   // ---------------- monitor, checker, watchdog ----------------

   always @(posedge clock) begin
      stereo_pair_type want;
      stereo_pair_type got;
      if (reset) begin
         mdl_filter_en = 1'b0;
         mdl_left_en   = 1'b1;
         mdl_right_en  = 1'b1;
         mdl_freq      = psm_pkg::FREQ_RESET;
         mdl_damping   = psm_pkg::DAMPING_RESET;
         lp_low        = '{0, 0};
         lp_band       = '{0, 0};
         quiet_cycles  <= 0;
      end else begin
         // register writes; spare indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               psm_pkg::CSR_FILTER_EN: mdl_filter_en = csr_data[0];
               psm_pkg::CSR_LEFT_EN:   mdl_left_en   = csr_data[0];
               psm_pkg::CSR_RIGHT_EN:  mdl_right_en  = csr_data[0];
               psm_pkg::CSR_FREQ:      mdl_freq      = csr_data;
               psm_pkg::CSR_DAMPING:   mdl_damping   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_stereo_frame(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_samples.size() == 0) begin
               $error("unexpected rsp word %h", rsp_tdata);
               fail_count++;
            end else begin
               want = pending_samples.pop_front();
               if (got.left_sample !== want.left_sample) begin
                  $error("left_sample: expected %0d, got %0d",
                         want.left_sample, got.left_sample);
                  fail_count++;
               end
               if (got.right_sample !== want.right_sample) begin
                  $error("right_sample: expected %0d, got %0d",
                         want.right_sample, got.right_sample);
                  fail_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------- receiver ----------------

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // ---------------- drivers ----------------

   // offer one frame; tvalid stays high into the next call unless a gap is drawn
   task automatic send_frame(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c, b, a};
      do @(posedge clock); while (!req_tready);
   endtask

   // sender pauses until every result is back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [14:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_registers(input logic filt, input logic len, input logic ren,
                                    input logic [14:0] freq, input logic [14:0] damp);
      wait_drained();
      write_reg(psm_pkg::CSR_FILTER_EN, {14'd0, filt});
      write_reg(psm_pkg::CSR_LEFT_EN, {14'd0, len});
      write_reg(psm_pkg::CSR_RIGHT_EN, {14'd0, ren});
      write_reg(psm_pkg::CSR_FREQ, freq);
      write_reg(psm_pkg::CSR_DAMPING, damp);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_level();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1023));
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------- tests ----------------

   // mix corners with the filter off (reset settings)
   task automatic test_mix_extremes();
      send_frame(16'h0000, 16'h0000, 16'h0000);
      send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_frame(16'hFFFF, 16'h0000, 16'h0000);
      send_frame(16'h0000, 16'hFFFF, 16'h0000);
      send_frame(16'h0000, 16'h0000, 16'hFFFF);
      send_frame(16'h0180, 16'h02FF, 16'h0180);  // just under a divide-by-3 step
      send_frame(16'h0180, 16'h0300, 16'hAAAA);
      send_frame(16'h5555, 16'hAAAA, 16'h5555);
   endtask

   // muted channels give the midpoint and keep their state
   task automatic test_channel_mute();
      program_registers(1'b0, 1'b0, 1'b1, psm_pkg::FREQ_RESET, psm_pkg::DAMPING_RESET);
      send_frame(16'hFFFF, 16'h1234, 16'hFFFF);
      program_registers(1'b1, 1'b1, 1'b0, psm_pkg::FREQ_RESET, psm_pkg::DAMPING_RESET);
      send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
      program_registers(1'b1, 1'b0, 1'b0, psm_pkg::FREQ_RESET, psm_pkg::DAMPING_RESET);
      send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
   endtask

   // wide data on the flag registers keeps bit 0; spare indexes do nothing
   task automatic test_register_decode();
      wait_drained();
      write_reg(psm_pkg::CSR_FILTER_EN, 15'h7FFE);
      write_reg(psm_pkg::CSR_LEFT_EN, 15'h7FFF);
      write_reg(psm_pkg::CSR_RIGHT_EN, 15'h7FFF);
      for (int i = CSR_COUNT; i < (1 << $bits(csr_index)); i++) begin
         write_reg(3'(i), 15'($urandom));
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      send_frame(16'h8000, 16'h4000, 16'h2000);
      send_frame(16'hFFFF, 16'h0001, 16'h7FFF);
   endtask

   // step response, then unstable and frozen coefficient corners
   task automatic test_filter_step();
      program_registers(1'b1, 1'b1, 1'b1, psm_pkg::FREQ_RESET, psm_pkg::DAMPING_RESET);
      repeat (4) send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (2) send_frame(16'h0000, 16'h0000, 16'h0000);
      // damping far below 0.5 with maximum coefficient runs into saturation
      program_registers(1'b1, 1'b1, 1'b1, 15'h7FFF, 15'd0);
      repeat (4) send_frame(16'hFFFF, 16'hFFFF, 16'h0000);
      program_registers(1'b1, 1'b1, 1'b1, 15'd0, 15'h7FFF);
      repeat (2) send_frame(16'h0000, 16'hFFFF, 16'hFFFF);
   endtask

   // block fills behind a stalled receiver and holds off the sender
   task automatic test_output_backpressure();
      program_registers(1'b1, 1'b1, 1'b1, psm_pkg::FREQ_RESET, psm_pkg::DAMPING_RESET);
      rsp_hold_req = 1'b1;
      repeat (40) send_frame(pick_level(), pick_level(), pick_level());
   endtask

   task automatic test_random_frames();
      logic [14:0] freq;
      logic [14:0] damp;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(3))
            0: freq = 15'h7FFF;
            1: freq = 15'd0;
            2: freq = 15'($urandom_range(2000));
            default: freq = 15'($urandom);
         endcase
         case ($urandom_range(4))
            0: damp = 15'h7FFF;
            1: damp = 15'd8192;
            2: damp = 15'($urandom_range(8191));
            3: damp = psm_pkg::DAMPING_RESET;
            default: damp = 15'($urandom);
         endcase
         // first two phases pin the coefficient extremes
         if (p == 0) begin
            freq = 15'h7FFF;
            damp = 15'h7FFF;
         end
         if (p == 1) begin
            freq = 15'd0;
            damp = 15'd0;
         end
         program_registers(($urandom_range(3) != 0), ($urandom_range(7) != 0),
                           ($urandom_range(7) != 0), freq, damp);
         no_gaps = (p == 3);
         repeat (PHASE_FRAMES) send_frame(pick_level(), pick_level(), pick_level());
      end
      no_gaps = 1'b0;
   endtask

   // ---------------- sequence ----------------

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      no_gaps      = 1'b0;
      rsp_hold_req = 1'b0;
      fail_count   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_mix_extremes();
      test_channel_mute();
      test_register_decode();
      test_filter_step();
      test_output_backpressure();
      test_random_frames();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_samples.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
